/* rtl/assert_macros.svh */
// Assertion macros for the LED dimmer RTL.
// Each macro samples on clk and is disabled while arst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication: when ante holds, cons holds at the same edge.
`define LDIM_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication: when ante holds, cons holds at the following edge.
`define LDIM_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/ldim_pkg.sv */
// Shared types, codes and constants for the LED dimmer.
// No dependencies; used by every module of the block.
package ldim_pkg;

	localparam int unsigned ADC_FULL      = 1023;
	localparam int unsigned PERCENT_SCALE = 100;

	localparam logic [7:0]  PWM_STEPS_RST = 8'd10;
	localparam logic [15:0] BLINK_INC_RST = 16'd100;
	localparam logic [15:0] BLINK_LIM_RST = 16'd500;

	// Configuration register indexes.
	localparam logic [1:0] CFG_PWM_STEPS = 2'd0;
	localparam logic [1:0] CFG_BLINK_INC = 2'd1;
	localparam logic [1:0] CFG_BLINK_LIM = 2'd2;

	// Item kinds.
	localparam logic OP_CONTROL = 1'b0;
	localparam logic OP_TICK    = 1'b1;

	// Control update modes.
	localparam logic [2:0] MODE_BREATHE    = 3'd0;
	localparam logic [2:0] MODE_STEADY     = 3'd1;
	localparam logic [2:0] MODE_STEADY_RPT = 3'd2;
	localparam logic [2:0] MODE_BLINK_RPT  = 3'd3;
	localparam logic [2:0] MODE_BLINK      = 3'd4;
	localparam logic [2:0] MODE_HOLD_RPT   = 3'd5;
	localparam logic [2:0] MODE_OFF        = 3'd6;

	typedef struct packed {
		logic [15:0] blink_limit;
		logic [15:0] blink_increment;
		logic [7:0]  pwm_steps;
	} cfg_t;

	typedef struct packed {
		logic [2:0] mode;
		logic [9:0] adc_sample;
		logic       operation;
	} item_t;

	typedef struct packed {
		logic       percent_report;
		logic [6:0] duty_percent;
		logic [7:0] duty_level;
		logic       led_on;
	} result_t;

	// Quotient by 1023 for products below 2^18: split at 1024 and fold the
	// high part back into the remainder, which then stays below twice 1023.
	function automatic logic [8:0] div_adc_full(input logic [17:0] x);
		logic [7:0]  q_hi;
		logic [10:0] rem;
		logic [8:0]  q;
		q_hi = x[17:10];
		rem  = {1'b0, x[9:0]} + {3'b000, q_hi};
		q    = {1'b0, q_hi};
		if (rem >= 11'(ADC_FULL))
			q = q + 9'd1;
		return q;
	endfunction

endpackage

/* rtl/led_pwm_breathe_blink_dimmer_unit.sv */
// LED dimmer top level: input register, dimmer core, result register, config.
// An accepted item goes through the input register, then the result register.
// Throughput: one item per cycle unless the master stalls; one core step per item.
// Reset (arst_n, asynchronous, active low) clears the pipeline, sets the
// configuration to 10 steps, increment 100, limit 500, and the dimmer state
// to duty 0, rising ramp, blink phase on, PWM running, LED off.
`include "assert_macros.svh"

module led_pwm_breathe_blink_dimmer_unit import ldim_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,   // adc_sample[9:0], mode[12:10], zero[15:13]
	input  logic        s_axis_tuser,   // operation
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,   // led_on[0], duty_level[8:1], duty_percent[15:9]
	output logic        m_axis_tuser,   // percent_report
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	cfg_t    cfg_q;
	item_t   item_s1;
	logic    valid_s1;
	result_t result_q;
	logic    out_valid_q;
	result_t result_d;
	logic    advance;
	logic    in_accept;

	assign cfg_ready     = 1'b1;
	assign advance       = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;
	assign in_accept     = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pwm_steps       <= PWM_STEPS_RST;
			cfg_q.blink_increment <= BLINK_INC_RST;
			cfg_q.blink_limit     <= BLINK_LIM_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_PWM_STEPS: cfg_q.pwm_steps       <= cfg_data[7:0];
				CFG_BLINK_INC: cfg_q.blink_increment <= cfg_data;
				CFG_BLINK_LIM: cfg_q.blink_limit     <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			valid_s1 <= in_accept || (valid_s1 && !advance);
			if (advance)
				out_valid_q <= 1'b1;
			else if (m_axis_tready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			item_s1.operation  <= s_axis_tuser;
			item_s1.adc_sample <= s_axis_tdata[9:0];
			item_s1.mode       <= s_axis_tdata[12:10];
		end
		if (advance)
			result_q <= result_d;
	end

	ldim_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.step   (advance),
		.item   (item_s1),
		.result (result_d)
	);

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {result_q.duty_percent, result_q.duty_level, result_q.led_on};
	assign m_axis_tuser  = result_q.percent_report;

	`LDIM_ASSERT_NEXT(a_accept_fills_s1, in_accept, valid_s1, "accepted item did not reach the input register")
	`LDIM_ASSERT_NEXT(a_advance_shows_result, advance, m_axis_tvalid, "processed item produced no result")
	`LDIM_ASSERT_SAME(a_percent_range, m_axis_tvalid && m_axis_tuser, m_axis_tdata[15:9] <= 7'd100, "reported percentage above 100")
	`LDIM_ASSERT_SAME(a_percent_zero, m_axis_tvalid && !m_axis_tuser, m_axis_tdata[15:9] == 7'd0, "percentage nonzero without report")

endmodule

/* rtl/ldim_scale.sv */
// Sample scaling for the LED dimmer: duty level from the potentiometer
// sample and the step count, and the sample as a percentage. Uses ldim_pkg.
module ldim_scale import ldim_pkg::*; (
	input  logic [9:0] adc_sample,
	input  logic [7:0] pwm_steps,
	output logic [7:0] level,
	output logic [6:0] percent
);

	logic [17:0] level_prod;
	logic [16:0] pct_prod;
	logic [8:0]  level_q9;
	logic [8:0]  pct_q9;

	always_comb begin
		level_prod = 18'(adc_sample) * 18'(pwm_steps);
		pct_prod   = 17'(adc_sample) * 17'(PERCENT_SCALE);
		level_q9   = div_adc_full(level_prod);
		pct_q9     = div_adc_full({1'b0, pct_prod});
		level      = level_q9[7:0];
		percent    = pct_q9[6:0];
	end

endmodule

/* rtl/ldim_core.sv */
// Dimmer state and next-state logic: blink accumulator, breathing ramp,
// duty level and PWM counter. Uses ldim_pkg and ldim_scale.
module ldim_core import ldim_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  cfg_t    cfg,
	input  logic    step,
	input  item_t   item,
	output result_t result
);

	logic [7:0]  duty_q;
	logic        ramp_down_q;
	logic [7:0]  pwm_count_q;
	logic [15:0] blink_accum_q;
	logic        blink_phase_q;
	logic        pwm_running_q;
	logic        led_level_q;

	logic [7:0]  duty_d;
	logic        ramp_down_d;
	logic [7:0]  pwm_count_d;
	logic [15:0] blink_accum_d;
	logic        blink_phase_d;
	logic        pwm_running_d;
	logic        led_level_d;

	logic [7:0]  scaled;
	logic [6:0]  percent;
	logic [15:0] accum_sum;
	logic [8:0]  ramp_next;
	logic        ramp_wrap;
	logic [8:0]  cnt_next;
	logic        report;

	ldim_scale u_scale (
		.adc_sample (item.adc_sample),
		.pwm_steps  (cfg.pwm_steps),
		.level      (scaled),
		.percent    (percent)
	);

	always_comb begin
		duty_d        = duty_q;
		ramp_down_d   = ramp_down_q;
		pwm_count_d   = pwm_count_q;
		blink_accum_d = blink_accum_q;
		blink_phase_d = blink_phase_q;
		pwm_running_d = pwm_running_q;
		led_level_d   = led_level_q;
		report        = 1'b0;

		accum_sum = blink_accum_q + cfg.blink_increment;
		ramp_wrap = ramp_down_q && (duty_q == 8'd0);
		ramp_next = ramp_down_q ? ({1'b0, duty_q} - 9'd1) : ({1'b0, duty_q} + 9'd1);
		cnt_next  = {1'b0, pwm_count_q} + 9'd1;

		if (item.operation == OP_TICK) begin
			if (pwm_running_q) begin
				led_level_d = (cnt_next < {1'b0, duty_q});
				pwm_count_d = (cnt_next >= {1'b0, cfg.pwm_steps}) ? 8'd0 : cnt_next[7:0];
			end
		end else begin
			if (accum_sum >= cfg.blink_limit) begin
				blink_accum_d = 16'd0;
				blink_phase_d = !blink_phase_q;
			end else begin
				blink_accum_d = accum_sum;
			end

			report = (item.mode inside {MODE_STEADY_RPT, MODE_BLINK_RPT, MODE_HOLD_RPT});

			case (item.mode)
				MODE_BREATHE: begin
					pwm_running_d = 1'b1;
					// A step down from zero wraps to full and clamps like an overshoot.
					if (ramp_wrap || (ramp_next >= {1'b0, cfg.pwm_steps})) begin
						duty_d      = cfg.pwm_steps;
						ramp_down_d = 1'b1;
					end else begin
						duty_d = ramp_next[7:0];
						if (ramp_next == 9'd0)
							ramp_down_d = 1'b0;
					end
				end
				MODE_STEADY, MODE_STEADY_RPT: begin
					pwm_running_d = 1'b1;
					duty_d        = scaled;
				end
				MODE_BLINK_RPT, MODE_BLINK: begin
					pwm_running_d = 1'b1;
					duty_d        = blink_phase_d ? scaled : 8'd0;
				end
				MODE_HOLD_RPT: begin
					pwm_running_d = 1'b0;
					duty_d        = scaled;
				end
				default: begin
					pwm_running_d = 1'b0;
					led_level_d   = 1'b0;
				end
			endcase
		end

		result.led_on         = led_level_d;
		result.duty_level     = duty_d;
		result.duty_percent   = report ? percent : 7'd0;
		result.percent_report = report;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			duty_q        <= 8'd0;
			ramp_down_q   <= 1'b0;
			pwm_count_q   <= 8'd0;
			blink_accum_q <= 16'd0;
			blink_phase_q <= 1'b1;
			pwm_running_q <= 1'b1;
			led_level_q   <= 1'b0;
		end else if (step) begin
			duty_q        <= duty_d;
			ramp_down_q   <= ramp_down_d;
			pwm_count_q   <= pwm_count_d;
			blink_accum_q <= blink_accum_d;
			blink_phase_q <= blink_phase_d;
			pwm_running_q <= pwm_running_d;
			led_level_q   <= led_level_d;
		end
	end

endmodule

/* bench/ldim_result_checker.sv */
`timescale 1ns / 100ps
// Result checker for the LED dimmer unit: it follows configuration and input
// transactions, predicts each result and compares the master-side stream.
// Depends on ldim_pkg for the item, result and code definitions.
module ldim_result_checker import ldim_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	input  logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,   // adc_sample[9:0], mode[12:10], zero[15:13]
	input  logic        s_axis_tuser,   // operation
	input  logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	input  logic [15:0] m_axis_tdata,   // led_on[0], duty_level[8:1], duty_percent[15:9]
	input  logic        m_axis_tuser,   // percent_report
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data,
	output int          mismatches,
	output int          outstanding
);

	bit [7:0]  steps_cfg;
	bit [15:0] blink_step_cfg;
	bit [15:0] blink_limit_cfg;

	bit [7:0]  duty;
	bit        ramp_falling;
	bit [7:0]  pwm_counter;
	bit [15:0] blink_acc;
	bit        blink_on;
	bit        pwm_on;
	bit        led;

	result_t   results_due[$];
	int        fail_count = 0;
	int        due_count = 0;
	int        results_seen = 0;

	assign mismatches  = fail_count;
	assign outstanding = due_count;

	function automatic bit [7:0] scaled_duty(bit [9:0] sample);
		int unsigned product;
		product = int'(sample) * int'(steps_cfg);
		return 8'(product / ADC_FULL);
	endfunction

	// One step of the breathing ramp. Stepping down from zero wraps to full,
	// which the clamp then turns into the top level with the ramp still falling.
	function automatic void breathe_step();
		bit [8:0] next_level;
		bit       wrapped;
		wrapped = ramp_falling && (duty == 8'd0);
		next_level = ramp_falling ? {1'b0, duty} - 9'd1 : {1'b0, duty} + 9'd1;
		if (wrapped || next_level >= {1'b0, steps_cfg}) begin
			duty = steps_cfg;
			ramp_falling = 1'b1;
		end else begin
			duty = next_level[7:0];
			if (next_level == 9'd0)
				ramp_falling = 1'b0;
		end
	endfunction

	function automatic result_t dimmer_result(item_t it);
		result_t  r;
		bit       report;
		bit [8:0] count_next;
		r = '0;
		report = 1'b0;
		if (it.operation == OP_TICK) begin
			if (pwm_on) begin
				count_next = {1'b0, pwm_counter} + 9'd1;
				led = (count_next < {1'b0, duty});
				pwm_counter = (count_next >= {1'b0, steps_cfg}) ? 8'd0 : count_next[7:0];
			end
		end else begin
			blink_acc = blink_acc + blink_step_cfg;
			if (blink_acc >= blink_limit_cfg) begin
				blink_acc = 16'd0;
				blink_on = !blink_on;
			end
			case (it.mode)
				MODE_BREATHE: begin
					pwm_on = 1'b1;
					breathe_step();
				end
				MODE_STEADY: begin
					pwm_on = 1'b1;
					duty = scaled_duty(it.adc_sample);
				end
				MODE_STEADY_RPT: begin
					pwm_on = 1'b1;
					duty = scaled_duty(it.adc_sample);
					report = 1'b1;
				end
				MODE_BLINK_RPT: begin
					pwm_on = 1'b1;
					duty = blink_on ? scaled_duty(it.adc_sample) : 8'd0;
					report = 1'b1;
				end
				MODE_BLINK: begin
					pwm_on = 1'b1;
					duty = blink_on ? scaled_duty(it.adc_sample) : 8'd0;
				end
				MODE_HOLD_RPT: begin
					pwm_on = 1'b0;
					duty = scaled_duty(it.adc_sample);
					report = 1'b1;
				end
				default: begin
					// Off and the unused code: PWM stops, LED low, duty kept.
					pwm_on = 1'b0;
					led = 1'b0;
				end
			endcase
			if (report)
				r.duty_percent = 7'((int'(it.adc_sample) * PERCENT_SCALE) / ADC_FULL);
		end
		r.led_on = led;
		r.duty_level = duty;
		r.percent_report = report;
		return r;
	endfunction

	task automatic report_mismatch(string field, int unsigned got, int unsigned want);
		$display("[%0t] result %0d: %s is %0d, expected %0d",
			$realtime, results_seen, field, got, want);
		fail_count++;
	endtask

	task automatic check_result(result_t got);
		result_t want;
		if (results_due.size() == 0) begin
			report_mismatch("unexpected result, raw value", got, 0);
		end else begin
			want = results_due.pop_front();
			if (got.led_on != want.led_on)
				report_mismatch("led_on", got.led_on, want.led_on);
			if (got.duty_level != want.duty_level)
				report_mismatch("duty_level", got.duty_level, want.duty_level);
			if (got.duty_percent != want.duty_percent)
				report_mismatch("duty_percent", got.duty_percent, want.duty_percent);
			if (got.percent_report != want.percent_report)
				report_mismatch("percent_report", got.percent_report, want.percent_report);
		end
		results_seen++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			steps_cfg = PWM_STEPS_RST;
			blink_step_cfg = BLINK_INC_RST;
			blink_limit_cfg = BLINK_LIM_RST;
			duty = 8'd0;
			ramp_falling = 1'b0;
			pwm_counter = 8'd0;
			blink_acc = 16'd0;
			blink_on = 1'b1;
			pwm_on = 1'b1;
			led = 1'b0;
			results_due.delete();
			due_count <= 0;
		end else begin
			// Results are taken first so that an item accepted on the same edge
			// cannot be matched against its own result.
			if (m_axis_tvalid && m_axis_tready)
				check_result({m_axis_tuser, m_axis_tdata[15:9], m_axis_tdata[8:1],
					m_axis_tdata[0]});
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_PWM_STEPS: steps_cfg = cfg_data[7:0];
					CFG_BLINK_INC: blink_step_cfg = cfg_data;
					CFG_BLINK_LIM: blink_limit_cfg = cfg_data;
					default: ;
				endcase
			end
			if (s_axis_tvalid && s_axis_tready)
				results_due.push_back(dimmer_result({s_axis_tdata[12:10],
					s_axis_tdata[9:0], s_axis_tuser}));
			due_count <= results_due.size();
		end
	end

endmodule

/* bench/tb_led_pwm_breathe_blink_dimmer_unit.sv */
`timescale 1ns / 100ps
// Testbench top for the LED dimmer unit: clock, reset, stimulus and verdict.
// Depends on ldim_pkg, the dimmer RTL and ldim_result_checker.
module tb_led_pwm_breathe_blink_dimmer_unit import ldim_pkg::*; ();

	localparam logic [2:0] MODE_UNUSED = 3'd7;
	localparam int PIPE_LATENCY = 2;
	localparam int STALL_LIMIT  = 2000;
	localparam int PHASE_ITEMS  = 70;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic [15:0] s_axis_tdata = '0;
	logic        s_axis_tuser = 1'b0;
	logic        m_axis_tready = 1'b0;
	logic        cfg_valid = 1'b0;
	logic [1:0]  cfg_index = '0;
	logic [15:0] cfg_data = '0;
	wire         s_axis_tready;
	wire         m_axis_tvalid;
	wire  [15:0] m_axis_tdata;
	wire         m_axis_tuser;
	wire         cfg_ready;

	int mismatches;
	int outstanding;
	int send_gap_pct = 0;
	int recv_stall_pct = 0;
	int quiet_cycles = 0;

	led_pwm_breathe_blink_dimmer_unit dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	ldim_result_checker u_results (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.mismatches    (mismatches),
		.outstanding   (outstanding)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
	end

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
				(cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("[%0t] watchdog: no transaction for %0d cycles", $realtime, STALL_LIMIT);
			$display("FAILED: results differ");
			$finish;
		end
	end

	task automatic send_item(logic op, logic [9:0] sample, logic [2:0] mode);
		while (send_gap_pct != 0 && $urandom_range(99) < send_gap_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {3'b000, mode, sample};
		s_axis_tuser  <= op;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
	endtask

	// Sample and mode are don't-care on a tick, so they carry random bits.
	task automatic send_tick();
		send_item(OP_TICK, 10'($urandom_range(1023)), 3'($urandom_range(7)));
	endtask

	// Holds the sender off until every predicted result has come back.
	task automatic wait_for_results();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (PIPE_LATENCY + 2) @(posedge clk);
	endtask

	task automatic program_setting(logic [7:0] steps, logic [15:0] inc, logic [15:0] lim);
		logic [1:0]  idx [3];
		logic [15:0] val [3];
		idx = '{CFG_PWM_STEPS, CFG_BLINK_INC, CFG_BLINK_LIM};
		val = '{{8'h00, steps}, inc, lim};
		wait_for_results();
		for (int i = 0; i < 3; i++) begin
			cfg_valid <= 1'b1;
			cfg_index <= idx[i];
			cfg_data  <= val[i];
			@(posedge clk);
			while (!cfg_ready)
				@(posedge clk);
		end
		cfg_valid <= 1'b0;
	endtask

	// Mostly runs of one mode with ticks in between, so breathing ramps and
	// blink phases get far enough to matter; the mode changes now and then.
	task automatic run_random_phase();
		logic [2:0] mode;
		logic [9:0] sample;
		mode = 3'($urandom_range(6));
		for (int n = 0; n < PHASE_ITEMS; n++) begin
			if (n % 18 == 0) begin
				case ((n / 18) % 4)
					0: begin send_gap_pct = 0;  recv_stall_pct = 0;  end
					1: begin send_gap_pct = 50; recv_stall_pct = 0;  end
					2: begin send_gap_pct = 0;  recv_stall_pct = 50; end
					default: begin send_gap_pct = 25; recv_stall_pct = 25; end
				endcase
			end
			if ($urandom_range(99) < 55) begin
				send_tick();
			end else begin
				if ($urandom_range(99) < 20)
					mode = ($urandom_range(19) == 0) ? MODE_UNUSED : 3'($urandom_range(6));
				case ($urandom_range(9))
					0: sample = 10'd0;
					1: sample = 10'd1023;
					default: sample = 10'($urandom_range(1023));
				endcase
				send_item(OP_CONTROL, sample, mode);
			end
		end
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// A few items under the reset configuration.
		send_tick();
		send_item(OP_CONTROL, 10'd0, MODE_BREATHE);
		send_tick();

		// Three steps make the ramp turns and clamps reachable in a few items.
		program_setting(8'd3, 16'd100, 16'd500);
		repeat (4) send_item(OP_CONTROL, 10'd0, MODE_BREATHE);
		send_tick();
		send_tick();
		// Forcing zero while the ramp falls makes the next breathe step wrap.
		send_item(OP_CONTROL, 10'd0, MODE_STEADY);
		send_item(OP_CONTROL, 10'd0, MODE_BREATHE);
		send_item(OP_CONTROL, 10'd1023, MODE_STEADY_RPT);
		send_item(OP_CONTROL, 10'd1023, MODE_BLINK_RPT);
		send_item(OP_CONTROL, 10'd512, MODE_BLINK);
		send_item(OP_CONTROL, 10'd1, MODE_BLINK);
		send_item(OP_CONTROL, 10'd1023, MODE_HOLD_RPT);
		send_tick();
		send_item(OP_CONTROL, 10'd0, MODE_OFF);
		send_tick();
		send_item(OP_CONTROL, 10'd1023, MODE_UNUSED);
		send_item(OP_CONTROL, 10'd341, MODE_STEADY);
		send_item(OP_CONTROL, 10'd0, MODE_BREATHE);
		send_item(OP_CONTROL, 10'd0, MODE_BREATHE);
		send_tick();
		send_tick();
		send_item(OP_CONTROL, 10'd0, MODE_BLINK_RPT);

		program_setting(8'd255, 16'd0, 16'd65535);
		run_random_phase();
		program_setting(8'd1, 16'd65535, 16'd1);
		run_random_phase();
		program_setting(PWM_STEPS_RST, BLINK_INC_RST, BLINK_LIM_RST);
		run_random_phase();
		program_setting(8'($urandom_range(1, 255)), 16'($urandom_range(65535)),
			16'($urandom_range(1, 65535)));
		run_random_phase();
		// Large increment below the limit makes the accumulator wrap in 16 bits.
		program_setting(8'd7, 16'd40000, 16'd50000);
		run_random_phase();
		program_setting(8'($urandom_range(1, 255)), 16'($urandom_range(65535)),
			16'($urandom_range(1, 65535)));
		run_random_phase();

		wait_for_results();
		if (mismatches == 0 && outstanding == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule

/* files.f */
+incdir+rtl
rtl/ldim_pkg.sv
rtl/ldim_scale.sv
rtl/ldim_core.sv
rtl/led_pwm_breathe_blink_dimmer_unit.sv
bench/ldim_result_checker.sv
bench/tb_led_pwm_breathe_blink_dimmer_unit.sv
